### rtl/core/assert_macros.svh
// assertion macros shared by the running median rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### rtl/core/swm_pkg.sv
// shared types and constants of the running median filter
package swm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int OUT_W      = 33;
    localparam int CFG_W      = 7;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int WIN_RESET  = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int GROUP_SIZE = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    median_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic    step;
        logic    trim;
        sample_t sample;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic    valid;
        logic    gt;
        sample_t value;
    } cell_view_t;

endpackage

### rtl/core/swm_cell.sv
// one position of the sorted window chain
module swm_cell #(
    parameter int AGE_W = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swm_pkg::cell_ctrl_t   ctrl,
    input  logic [AGE_W-1:0]      del_target,
    input  logic                  del_below,
    input  logic                  del_here,
    input  swm_pkg::cell_view_t   prev_view,
    input  logic [AGE_W-1:0]      prev_age,
    input  swm_pkg::cell_view_t   next_view,
    input  logic [AGE_W-1:0]      next_age,
    output swm_pkg::cell_view_t   own_view,
    output logic [AGE_W-1:0]      own_age,
    output logic                  own_del
);
    import swm_pkg::*;

    logic             valid_reg, valid_next;
    sample_t          value_reg, value_next;
    logic [AGE_W-1:0] age_reg, age_next;

    cell_view_t       keep_view, fall_view;
    logic [AGE_W-1:0] keep_age, fall_age;

    assign own_view.valid = valid_reg;
    assign own_view.gt    = !valid_reg || (value_reg > ctrl.sample);
    assign own_view.value = value_reg;
    assign own_age        = age_reg;
    assign own_del        = valid_reg && (age_reg == del_target);

    always_comb begin
        // survivor at this position, and the one just below it
        keep_view = del_here  ? next_view : own_view;
        keep_age  = del_here  ? next_age  : age_reg;
        fall_view = del_below ? own_view  : prev_view;
        fall_age  = del_below ? age_reg   : prev_age;

        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.trim) begin
            valid_next = keep_view.valid;
            value_next = keep_view.value;
            age_next   = keep_age;
        end else if (ctrl.step) begin
            if (!keep_view.gt) begin
                valid_next = 1'b1;
                value_next = keep_view.value;
                age_next   = keep_age + AGE_W'(1);
            end else if (fall_view.gt) begin
                valid_next = fall_view.valid;
                value_next = fall_view.value;
                age_next   = fall_view.valid ? fall_age + AGE_W'(1) : '0;
            end else begin
                valid_next = 1'b1;
                value_next = ctrl.sample;
                age_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

### rtl/core/swm_fifo.sv
// small result buffer between the median pipeline and the output port
`include "assert_macros.svh"

module swm_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic                         out_valid,
    output logic [WIDTH-1:0]             out_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLIES(a_fifo_no_overflow, aclk, aresetn, push, (count_reg != CNT_W'(DEPTH)) || do_pop)

endmodule

### rtl/core/sliding_window_median_core.sv
// running median filter: a sorted chain of cells, read by rank, with a result buffer
//
// Takes one signed 32-bit sample per transfer and holds the most recent
// window_size samples in a chain of WINDOW_MAX cells kept in ascending order,
// each cell with the age of its sample. Every accepted sample is inserted and
// the oldest one dropped in the same clock, all cells moving at once, so the
// input takes one sample per clock back to back while not held off. Once the
// window is full, every sample yields one result on the output, the window
// median times two (33-bit two's complement, one fractional bit): twice the
// middle value for an odd window, the sum of the two middle values for an even
// one. The first window_size-1 samples after reset give no result. The median
// ranks of a result are picked out of the chain by a two-level registered
// select tree, then added, then written to an 8-entry output buffer. Input is
// held off only when that buffer, counting the results still in the pipeline,
// could not take one more, and after window_size was lowered, while the chain
// drops the samples that fell outside the shorter window, one per clock. The
// store is empty after reset, no clearing pass. window_size is written through
// cfg_wr_en only while the block is idle, a rule on the user that the block
// does not enforce; 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX.
`include "assert_macros.svh"

module sliding_window_median_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write: window_size
    input  logic                           cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [swm_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] sample
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]  m_axis_tdata    // [32:0] median_doubled, [39:33] zero
);
    import swm_pkg::*;

    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W      = CNT_W;
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NUM_GROUPS = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;
    localparam int WIN_INIT   = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W      = FIFO_CNT_W + 1;

    // configuration, kept in clipped form with its two median ranks
    logic [CNT_W-1:0] win_eff_reg;
    logic [IDX_W-1:0] med_lo_idx_reg, med_hi_idx_reg;
    logic [CNT_W-1:0] cfg_win;

    // chain control
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             trim;
    logic             step;
    logic             cell_op;
    logic [AGE_W-1:0] del_target;
    cell_ctrl_t       ctrl;

    // chain wiring
    cell_view_t            cell_view [WINDOW_MAX];
    logic [AGE_W-1:0]      cell_age  [WINDOW_MAX];
    cell_view_t            prev_view [WINDOW_MAX];
    logic [AGE_W-1:0]      prev_age  [WINDOW_MAX];
    cell_view_t            next_view [WINDOW_MAX];
    logic [AGE_W-1:0]      next_age  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] del_vec;
    logic [WINDOW_MAX-1:0] del_incl;
    logic [WINDOW_MAX-1:0] del_below;

    // median select tree and adder
    sample_t pad_val      [PAD_CELLS];
    sample_t part_lo_reg  [NUM_GROUPS];
    sample_t part_hi_reg  [NUM_GROUPS];
    sample_t part_lo_next [NUM_GROUPS];
    sample_t part_hi_next [NUM_GROUPS];
    sample_t med_lo_reg, med_hi_reg, med_lo_next, med_hi_next;
    logic    vld0_reg, vld1_reg, vld2_reg, vld0_next;
    median_t med_sum;

    // output buffer
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0]      occupancy;
    median_t               fifo_data;

    // ---------------------------------------------------------------
    // configuration: clip the window once at write time
    // ---------------------------------------------------------------
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_win = CNT_W'(1);
        end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
            cfg_win = CNT_W'(WINDOW_MAX);
        end else begin
            cfg_win = CNT_W'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_eff_reg    <= CNT_W'(WIN_INIT);
            med_lo_idx_reg <= IDX_W'((WIN_INIT - 1) / 2);
            med_hi_idx_reg <= IDX_W'(WIN_INIT / 2);
        end else if (cfg_wr_en) begin
            win_eff_reg    <= cfg_win;
            med_lo_idx_reg <= IDX_W'((cfg_win - CNT_W'(1)) >> 1);
            med_hi_idx_reg <= IDX_W'(cfg_win >> 1);
        end
    end

    // ---------------------------------------------------------------
    // input handshake and chain command
    // ---------------------------------------------------------------
    // more samples held than the window allows: drop the oldest, one a clock
    assign trim = (fill_reg > win_eff_reg);

    // credit check counts results already in the pipeline
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(vld0_reg) + OCC_W'(vld1_reg)
                     + OCC_W'(vld2_reg);
    assign s_axis_tready = !trim && (occupancy < OCC_W'(FIFO_DEPTH));

    assign step    = s_axis_tvalid && s_axis_tready;
    assign cell_op = step || trim;

    // a step drops the sample that reaches the window length, a trim the oldest
    assign del_target = trim ? fill_reg - CNT_W'(1) : win_eff_reg - CNT_W'(1);

    assign ctrl.step   = step;
    assign ctrl.trim   = trim;
    assign ctrl.sample = sample_t'(s_axis_tdata);

    always_comb begin
        fill_next = fill_reg;
        if (step) begin
            fill_next = (fill_reg == win_eff_reg) ? fill_reg : fill_reg + CNT_W'(1);
        end else if (trim) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // a result follows every transfer that leaves the window full
    assign vld0_next = step && (fill_next == win_eff_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            vld0_reg <= vld0_next;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
        end
    end

    // ---------------------------------------------------------------
    // sorted cell chain
    // ---------------------------------------------------------------
    // del_incl marks cells at or above the dropped one; those take from above
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_chain
        assign del_incl[k] = cell_op & (|del_vec[k:0]);

        if (k == 0) begin : g_bottom
            assign prev_view[k] = '{valid: 1'b0, gt: 1'b0, value: '0};
            assign prev_age[k]  = '0;
            assign del_below[k] = 1'b0;
        end else begin : g_inner_lo
            assign prev_view[k] = cell_view[k-1];
            assign prev_age[k]  = cell_age[k-1];
            assign del_below[k] = del_incl[k-1];
        end

        if (k == WINDOW_MAX - 1) begin : g_top
            assign next_view[k] = '{valid: 1'b0, gt: 1'b1, value: '0};
            assign next_age[k]  = '0;
        end else begin : g_inner_hi
            assign next_view[k] = cell_view[k+1];
            assign next_age[k]  = cell_age[k+1];
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .del_target (del_target),
            .del_below  (del_below[k]),
            .del_here   (del_incl[k]),
            .prev_view  (prev_view[k]),
            .prev_age   (prev_age[k]),
            .next_view  (next_view[k]),
            .next_age   (next_age[k]),
            .own_view   (cell_view[k]),
            .own_age    (cell_age[k]),
            .own_del    (del_vec[k])
        );
    end

    // ---------------------------------------------------------------
    // median by rank: group select, final select, add
    // ---------------------------------------------------------------
    for (genvar k = 0; k < PAD_CELLS; k++) begin : g_pad
        if (k < WINDOW_MAX) begin : g_real
            assign pad_val[k] = cell_view[k].value;
        end else begin : g_fill
            assign pad_val[k] = '0;
        end
    end

    // first level: one rank match inside each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            part_lo_next[g] = '0;
            part_hi_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (IDX_W'(g * GROUP_SIZE + j) == med_lo_idx_reg) begin
                    part_lo_next[g] = part_lo_next[g] | pad_val[g * GROUP_SIZE + j];
                end
                if (IDX_W'(g * GROUP_SIZE + j) == med_hi_idx_reg) begin
                    part_hi_next[g] = part_hi_next[g] | pad_val[g * GROUP_SIZE + j];
                end
            end
        end
    end

    // second level: merge the group results
    always_comb begin
        med_lo_next = '0;
        med_hi_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            med_lo_next = med_lo_next | part_lo_reg[g];
            med_hi_next = med_hi_next | part_hi_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        part_lo_reg <= part_lo_next;
        part_hi_reg <= part_hi_next;
        med_lo_reg  <= med_lo_next;
        med_hi_reg  <= med_hi_next;
    end

    // odd windows pick the same rank twice, so the sum is always the answer
    assign med_sum = median_t'(med_lo_reg) + median_t'(med_hi_reg);

    // ---------------------------------------------------------------
    // output buffer
    // ---------------------------------------------------------------
    swm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (vld2_reg),
        .push_data (med_sum),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, fifo_data};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // ages are unique, so at most one cell leaves per clock
    `ASSERT_IMPLIES(a_single_drop, aclk, aresetn, 1'b1, $onehot0(del_vec))
    `ASSERT_IMPLIES(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(WINDOW_MAX))
    // a full window stays full: one in, one out
    `ASSERT_NEXT(a_full_holds, aclk, aresetn, step && (fill_reg == win_eff_reg),
                 fill_reg == $past(fill_reg))

endmodule
